// ===== sv/bagb_pkg.sv =====
// Shared types and constants for the bit-aligned glyph blit.
`default_nettype none

package bagb_pkg;

  localparam int PADDR_W = 12;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 24;

  localparam logic CMD_BLIT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] CFG_PAGE_SELECT   = 2'd0;
  localparam logic [1:0] CFG_INSERT_CURSOR = 2'd1;
  localparam logic [1:0] CFG_DELETE_CURSOR = 2'd2;
  localparam logic [1:0] CFG_DIRECT_DRAW   = 2'd3;

  typedef struct packed {
    logic               is_read;
    logic [PADDR_W-1:0] addr;
    logic [7:0]         data;
    logic [3:0]         limit;
    logic [2:0]         offset;
    logic               last;
    logic               hi_ok;
    logic               in_page;
  } desc_t;

  typedef struct packed {
    logic [8:0] addr;
    logic [7:0] value;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/bagb_front.sv =====
// Front end: unpack an input word, reject or drop it, and build a descriptor.
`default_nettype none

module bagb_front import bagb_pkg::*; #(
  parameter int ROWS = 16,
  parameter int COLS = 128
) (
  input  wire logic [IN_W-1:0] s_tdata,
  input  wire logic            s_tuser,
  input  wire logic            insert_cursor,
  input  wire logic            delete_cursor,
  output desc_t                desc,
  output logic                 keep
);

  localparam int R8         = ROWS / 8;
  localparam int PAGE_BYTES = COLS * R8;

  logic signed [9:0] ys;
  logic signed [9:0] ymax;
  logic [8:0]        xu;
  logic [8:0]        wsum;
  logic [8:0]        wclip;
  logic [8:0]        xc;
  logic [6:0]        w;
  logic [6:0]        h;
  logic [3:0]        bpc;
  logic [5:0]        col;
  logic [2:0]        bk;
  logic [3:0]        nb;
  logic [7:0]        gbyte;
  logic [8:0]        ra;
  logic              x_bad;
  logic              step_bad;
  logic [PADDR_W-1:0] addr;
  logic [7:0]        data;

  always_comb begin
    w     = s_tdata[22:16];
    h     = s_tdata[29:23];
    bpc   = s_tdata[33:30];
    col   = s_tdata[39:34];
    bk    = s_tdata[42:40];
    gbyte = s_tdata[50:43];
    ra    = s_tdata[59:51];
    nb    = {1'b0, bk} + 4'd1;

    ys   = {{2{s_tdata[15]}}, s_tdata[15:8]};
    ymax = 10'(ROWS) - {3'b0, h};
    xu   = {1'b0, s_tdata[7:0]};
    wsum = xu + {2'b0, w};

    x_bad = s_tdata[7];
    wclip = {2'b0, w};
    if (wsum > 9'(COLS)) begin
      if (xu < 9'(COLS)) wclip = 9'(COLS) - xu;
      else x_bad = 1'b1;
    end

    if ({1'b0, bk} >= bpc) step_bad = 1'b1;
    else if (bk == 3'd0) step_bad = (h == 7'd0);
    else step_bad = ({1'b0, h} < ({2'b0, bk, 3'b0} + 8'd8));

    xc   = xu + {3'b0, col};
    addr = PADDR_W'(xc) * PADDR_W'(R8) + PADDR_W'(s_tdata[14:11]) + PADDR_W'(bk);

    data = gbyte;
    if (insert_cursor && col < 6'd2) data = ~data;
    if (delete_cursor) data = ~data;

    desc.is_read = (s_tuser == CMD_READ);
    desc.data    = data;
    desc.offset  = s_tdata[10:8];
    desc.limit   = (bk == 3'd0 && h < 7'd8) ? h[3:0] : 4'd8;
    desc.last    = (nb >= bpc) || ({1'b0, h} < ({1'b0, nb, 3'b0} + 8'd8));
    desc.hi_ok   = ({1'b0, addr} + (PADDR_W+1)'(1)) < (PADDR_W+1)'(PAGE_BYTES);
    desc.in_page = ({3'b0, ra} < PADDR_W'(PAGE_BYTES));
    desc.addr    = desc.is_read ? PADDR_W'(ra) : addr;

    keep = desc.is_read ||
           !(ys < 10'sd0 || ys > ymax || x_bad ||
             {3'b0, col} >= wclip || step_bad);
  end

endmodule

`default_nettype wire

// ===== sv/bagb_queue.sv =====
// Two-entry descriptor queue between the front and back ends.
`default_nettype none

module bagb_queue import bagb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  desc_t      wdata,
  input  wire logic  pop,
  output desc_t      rdata,
  output logic       not_empty,
  output logic       not_full
);

  desc_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign rdata     = entry[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign not_full  = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== sv/bagb_back.sv =====
// Back end: banked frame store, read-modify-write sequencer and result buffer.
`default_nettype none

module bagb_back import bagb_pkg::*; #(
  parameter int ROWS  = 16,
  parameter int COLS  = 128,
  parameter int PAGES = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  desc_t     head,
  input  wire logic q_valid,
  output logic      pop,
  input  wire logic page_select,
  input  wire logic direct_draw,
  output logic      clearing,
  output logic      m_tvalid,
  input  wire logic m_tready,
  output res_t      m_res
);

  localparam int PAGE_BYTES = COLS * (ROWS / 8);
  localparam int STORE      = PAGES * PAGE_BYTES;
  localparam int SA_W       = $clog2(STORE);
  localparam int BI_W       = SA_W - 1;
  localparam int BANK_D     = 1 << BI_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [BI_W-1:0] clr_cnt;
  desc_t           cur;
  desc_t           sel;

  logic [7:0] ev_mem [BANK_D];
  logic [7:0] od_mem [BANK_D];
  logic [7:0] ev_q;
  logic [7:0] od_q;
  logic [BI_W-1:0] ev_a;
  logic [BI_W-1:0] od_a;
  logic [7:0] ev_wd;
  logic [7:0] od_wd;
  logic ev_we;
  logic od_we;

  logic [SA_W-1:0] base;
  logic [SA_W-1:0] phys;
  logic [BI_W-1:0] row;
  logic            lo_par;
  logic [7:0]      lo_b;
  logic [7:0]      hi_b;
  logic [7:0]      field;
  logic [15:0]     win;
  logic [15:0]     ins;
  logic [15:0]     nw;
  logic            two;
  logic            go;
  logic            ok_load;
  logic            take;
  logic [1:0]      n_res;
  logic [1:0]      cnt;
  res_t            r0;
  res_t            r1;
  res_t            slot0;
  res_t            slot1;

  assign clearing = (state == ST_CLR);
  assign pop      = (state == ST_IDLE) && q_valid;
  assign take     = m_tvalid && m_tready;
  assign ok_load  = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign go       = (state == ST_WR) && ok_load;
  assign m_tvalid = (cnt != 2'd0);
  assign m_res    = slot0;

  always_comb begin
    base   = (PAGES > 1 && page_select) ? SA_W'(PAGE_BYTES) : '0;
    sel    = (state == ST_IDLE) ? head : cur;
    phys   = base + SA_W'(sel.addr);
    lo_par = phys[0];
    row    = phys[SA_W-1:1];

    lo_b  = lo_par ? od_q : ev_q;
    hi_b  = lo_par ? ev_q : od_q;
    field = 8'((9'd1 << cur.limit) - 9'd1);
    win   = {8'h00, field} << cur.offset;
    ins   = {8'h00, cur.data & field} << cur.offset;
    nw    = ({hi_b, lo_b} & ~win) | ins;

    if (clearing) begin
      ev_a  = clr_cnt;
      od_a  = clr_cnt;
      ev_wd = 8'h00;
      od_wd = 8'h00;
      ev_we = 1'b1;
      od_we = 1'b1;
    end else begin
      ev_a  = lo_par ? row + BI_W'(1) : row;
      od_a  = row;
      ev_wd = lo_par ? nw[15:8] : nw[7:0];
      od_wd = lo_par ? nw[7:0] : nw[15:8];
      ev_we = go && !cur.is_read && (!lo_par || cur.hi_ok);
      od_we = go && !cur.is_read && (lo_par || cur.hi_ok);
    end

    two      = !cur.is_read && cur.last && (cur.offset != 3'd0) && cur.hi_ok;
    r0.addr  = cur.addr[8:0];
    r0.value = cur.is_read ? (cur.in_page ? lo_b : 8'h00) : nw[7:0];
    r0.last  = !two;
    r1.addr  = cur.addr[8:0] + 9'd1;
    r1.value = nw[15:8];
    r1.last  = 1'b1;
    if (cur.is_read) n_res = 2'd1;
    else if (!direct_draw) n_res = 2'd0;
    else n_res = two ? 2'd2 : 2'd1;
  end

  always_ff @(posedge clk) begin
    if (ev_we) ev_mem[ev_a] <= ev_wd;
    ev_q <= ev_mem[ev_a];
  end

  always_ff @(posedge clk) begin
    if (od_we) od_mem[od_a] <= od_wd;
    od_q <= od_mem[od_a];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR: begin
        if (clr_cnt == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) state_next = ST_WR;
      end
      ST_WR: begin
        if (ok_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (go) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (take) begin
      slot0 <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_cnt <= '0;
      cnt     <= 2'd0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + BI_W'(1);
      if (go) cnt <= n_res;
      else if (take) cnt <= cnt - 2'd1;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR && !ok_load) |=> (state == ST_WR && $stable(cur)))
    else $error("stalled item changed before its write");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (cnt == 2'd0 && !pop))
    else $error("activity during clearing pass");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(ev_we || od_we))
    else $error("store written outside write step");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    go |=> (cnt <= 2'd2))
    else $error("result buffer overfilled");

endmodule

`default_nettype wire

// ===== sv/bit_aligned_glyph_blit.sv =====
// Top level of the bit-aligned glyph blit: config registers and stream ports.
//
//  channel  dir  handshake          payload
//  s        in   s_tvalid/s_tready  s_tdata (blit/read fields), s_tuser (cmd)
//  m        out  m_tvalid/m_tready  m_tdata (buf_addr, buf_byte), m_tlast
//  cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// In the back end an item is read from both banks of the even/odd split store
// in the idle state, then written back with the result buffer loaded in the write state.
// A blit reporting two bytes holds the buffer until both output words are taken.
// After reset a clearing pass zeroes the store, one row of both banks per
// cycle, with s_tready low meanwhile.
// The two-entry queue lets the front keep accepting while the back stalls, until it fills.
`default_nettype none

module bit_aligned_glyph_blit import bagb_pkg::*; #(
  parameter int ROWS  = 16,
  parameter int COLS  = 128,
  parameter int PAGES = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // pos_x[7:0] pos_y[15:8] glyph_width[22:16] glyph_height[29:23]
  // bytes_per_col[33:30] col_index[39:34] byte_index[42:40]
  // glyph_byte[50:43] read_addr[59:51], zero above
  input  wire logic [IN_W-1:0]  s_tdata,
  // cmd
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // buf_addr[8:0] buf_byte[16:9], zero above
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tlast,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic             cfg_data
);

  logic  page_select;
  logic  insert_cursor;
  logic  delete_cursor;
  logic  direct_draw;
  desc_t f_desc;
  desc_t q_head;
  logic  f_keep;
  logic  q_not_empty;
  logic  q_not_full;
  logic  pop;
  logic  clearing;
  logic  push;
  res_t  m_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = q_not_full && !clearing;
  assign push      = s_tvalid && s_tready && f_keep;
  assign m_tdata   = {7'b0, m_res.value, m_res.addr};
  assign m_tlast   = m_res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_select   <= 1'b0;
      insert_cursor <= 1'b0;
      delete_cursor <= 1'b0;
      direct_draw   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAGE_SELECT:   page_select   <= cfg_data;
        CFG_INSERT_CURSOR: insert_cursor <= cfg_data;
        CFG_DELETE_CURSOR: delete_cursor <= cfg_data;
        CFG_DIRECT_DRAW:   direct_draw   <= cfg_data;
        default: ;
      endcase
    end
  end

  bagb_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .insert_cursor (insert_cursor),
    .delete_cursor (delete_cursor),
    .desc          (f_desc),
    .keep          (f_keep)
  );

  bagb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (f_desc),
    .pop       (pop),
    .rdata     (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  bagb_back #(
    .ROWS  (ROWS),
    .COLS  (COLS),
    .PAGES (PAGES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_valid     (q_not_empty),
    .pop         (pop),
    .page_select (page_select),
    .direct_draw (direct_draw),
    .clearing    (clearing),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_res       (m_res)
  );

endmodule

`default_nettype wire

// ===== test/bit_aligned_glyph_blit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the glyph blit: tracks the frame store, predicts output words, compares.
module bit_aligned_glyph_blit_checker import bagb_pkg::*; #(
  parameter int ROWS  = 16,
  parameter int COLS  = 128,
  parameter int PAGES = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  input  logic            s_tuser,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic            m_tlast,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic            cfg_data,
  output int              fail_count,
  output int              pending
);

  localparam int PAGE_BYTES = COLS * (ROWS / 8);

  logic [7:0] frame_mem [PAGES*PAGE_BYTES];
  logic       page_sel;
  logic       ins_cursor;
  logic       del_cursor;
  logic       draw_on;
  res_t       due_q [$];
  int         fails;

  function automatic bit step_live(int k, int bpc, int h);
    if (k >= bpc) return 0;
    if (k == 0) return h > 0;
    return h >= 8 * k + 8;
  endfunction

  task automatic predict_word(input logic cmd, input logic [IN_W-1:0] f);
    int          base, x, y, w, h, bpc, col, k, addr, offset, limit;
    logic [8:0]  ra;
    logic [7:0]  glyph;
    logic [15:0] field, win, pair;
    bit          hi_ok, last;
    res_t        r;
    base = (int'(page_sel) % PAGES) * PAGE_BYTES;
    if (cmd == CMD_READ) begin
      ra = f[59:51];
      r.addr = ra;
      r.value = (int'(ra) < PAGE_BYTES) ? frame_mem[base + int'(ra)] : 8'h00;
      r.last = 1'b1;
      due_q.push_back(r);
      return;
    end
    x = int'($signed(f[7:0]));
    y = int'($signed(f[15:8]));
    w = int'(f[22:16]);
    h = int'(f[29:23]);
    bpc = int'(f[33:30]);
    col = int'(f[39:34]);
    k = int'(f[42:40]);
    glyph = f[50:43];
    if (y < 0 || y > ROWS - h || x < 0) return;
    if (x + w > COLS) begin
      if (x < COLS) w = COLS - x;
      else return;
    end
    if (col >= w || !step_live(k, bpc, h)) return;

    limit = (k == 0 && h < 8) ? h : 8;
    offset = y & 7;
    addr = (x + col) * (ROWS / 8) + y / 8 + k;
    if (ins_cursor && col < 2) glyph = ~glyph;
    if (del_cursor) glyph = ~glyph;

    field = (16'd1 << limit) - 16'd1;
    win = field << offset;
    hi_ok = (addr + 1) < PAGE_BYTES;
    pair = {8'h00, frame_mem[base + addr]};
    if (hi_ok) pair[15:8] = frame_mem[base + addr + 1];
    pair = (pair & ~win) | (({8'h00, glyph} & field) << offset);
    frame_mem[base + addr] = pair[7:0];
    if (hi_ok) frame_mem[base + addr + 1] = pair[15:8];

    if (!draw_on) return;
    last = !step_live(k + 1, bpc, h);
    r.addr = addr[8:0];
    r.value = pair[7:0];
    r.last = 1'b1;
    if (last && offset != 0 && hi_ok) begin
      r.last = 1'b0;
      due_q.push_back(r);
      r.addr = 9'(addr + 1);
      r.value = pair[15:8];
      r.last = 1'b1;
    end
    due_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    res_t got, want;
    if (rst) begin
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      page_sel = 1'b0;
      ins_cursor = 1'b0;
      del_cursor = 1'b0;
      draw_on = 1'b0;
      due_q.delete();
      fails = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.addr = m_tdata[8:0];
        got.value = m_tdata[16:9];
        got.last = m_tlast;
        if (due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected word addr %0d byte %02h last %0b",
                     $time, got.addr, got.value, got.last);
        end else begin
          want = due_q.pop_front();
          if (got.addr !== want.addr || got.value !== want.value ||
              got.last !== want.last) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: mismatch expected addr %0d byte %02h last %0b,",
                        " got addr %0d byte %02h last %0b"},
                       $time, want.addr, want.value, want.last,
                       got.addr, got.value, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGE_SELECT:   page_sel = cfg_data;
          CFG_INSERT_CURSOR: ins_cursor = cfg_data;
          CFG_DELETE_CURSOR: del_cursor = cfg_data;
          CFG_DIRECT_DRAW:   draw_on = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_word(s_tuser, s_tdata);
    end
    fail_count <= fails;
    pending <= due_q.size();
  end

endmodule

// ===== test/bit_aligned_glyph_blit_test.sv =====
`timescale 1ns / 100ps
// Top of the glyph blit testbench: clock, reset, stimulus, watchdog and verdict.
module bit_aligned_glyph_blit_test;
  import bagb_pkg::*;

  localparam int ROWS        = 16;
  localparam int COLS        = 128;
  localparam int PAGES       = 2;
  localparam int PAGE_BYTES  = COLS * (ROWS / 8);
  localparam int SETTLE      = 16;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_ITEMS = 185;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic             cfg_data = 1'b0;

  int fail_count;
  int pending;
  int tx_pct = 0;
  int rx_pct = 0;
  int rx_hold = 0;
  int items = 0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bit_aligned_glyph_blit #(.ROWS(ROWS), .COLS(COLS), .PAGES(PAGES)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bit_aligned_glyph_blit_checker #(.ROWS(ROWS), .COLS(COLS), .PAGES(PAGES)) CHECK (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int pick_gap(int pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [IN_W-1:0] make_blit(int x, int y, int w, int h, int bpc,
                                                int col, int k, int glyph);
    logic [IN_W-1:0] f;
    f = '0;
    f[7:0] = x[7:0];
    f[15:8] = y[7:0];
    f[22:16] = w[6:0];
    f[29:23] = h[6:0];
    f[33:30] = bpc[3:0];
    f[39:34] = col[5:0];
    f[42:40] = k[2:0];
    f[50:43] = glyph[7:0];
    return f;
  endfunction

  function automatic logic [IN_W-1:0] make_read(int addr);
    logic [IN_W-1:0] f;
    f = '0;
    f[59:51] = addr[8:0];
    return f;
  endfunction

  // hold each word until accepted
  task automatic send_word(input logic cmd, input logic [IN_W-1:0] fields);
    int gap;
    gap = pick_gap(tx_pct);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= fields;
    do @(posedge clk); while (!s_tready);
    items++;
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic page, input logic ins, input logic del,
                               input logic draw);
    write_reg(CFG_PAGE_SELECT, page);
    write_reg(CFG_INSERT_CURSOR, ins);
    write_reg(CFG_DELETE_CURSOR, del);
    write_reg(CFG_DIRECT_DRAW, draw);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_glyph();
    int x, y, w, h, bpc, ncol, first;
    h = ($urandom_range(3, 0) == 0) ? $urandom_range(ROWS, 8) : $urandom_range(8, 1);
    y = $urandom_range(ROWS - h, 0);
    x = $urandom_range(COLS - 1, 0);
    w = ($urandom_range(7, 0) == 0) ? $urandom_range(64, 7) : $urandom_range(6, 1);
    bpc = ($urandom_range(4, 0) == 0) ? $urandom_range(8, 1) : (h + 7) / 8;
    ncol = (w < 6) ? w : 6;
    first = $urandom_range(w - ncol, 0);
    for (int c = first; c < first + ncol; c++)
      for (int k = 0; k < bpc; k++)
        send_word(CMD_BLIT, make_blit(x, y, w, h, bpc, c, k, $urandom_range(255, 0)));
  endtask

  // receiver pacing
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      rx_hold <= pick_gap(rx_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("bit_aligned_glyph_blit_test NOT OK");
      $finish;
    end
  end

  initial begin
    int pick;
    logic [IN_W-1:0] noise;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    tx_pct = 20;
    rx_pct = 20;
    load_settings(1'b0, 1'b0, 1'b0, 1'b1);
    send_word(CMD_BLIT, make_blit(0, 0, 1, 8, 1, 0, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(127, 15, 1, 1, 1, 0, 0, 8'ha5));
    send_word(CMD_BLIT, make_blit(10, 3, 2, 8, 1, 1, 0, 8'h5a));
    send_word(CMD_BLIT, make_blit(20, 0, 4, 16, 2, 0, 0, 8'h3c));
    send_word(CMD_BLIT, make_blit(20, 0, 4, 16, 2, 0, 1, 8'hc3));
    send_word(CMD_BLIT, make_blit(30, 2, 1, 12, 2, 0, 0, 8'h00));
    send_word(CMD_BLIT, make_blit(30, 2, 1, 12, 2, 0, 1, 8'hff));
    send_word(CMD_BLIT, make_blit(40, -1, 1, 8, 1, 0, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(40, 9, 1, 8, 1, 0, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(-128, 0, 1, 8, 1, 0, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(127, 0, 64, 8, 1, 1, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(127, 0, 64, 8, 1, 0, 0, 8'h81));
    send_word(CMD_BLIT, make_blit(50, 4, 3, 0, 1, 0, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(50, 4, 3, 8, 1, 0, 1, 8'hff));
    send_word(CMD_BLIT, make_blit(50, 4, 3, 8, 0, 0, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(60, 0, 127, 127, 15, 63, 7, 8'hff));
    send_word(CMD_BLIT, make_blit(60, 0, 0, 4, 1, 0, 0, 8'hff));
    send_word(CMD_BLIT, make_blit(100, 7, 2, 1, 1, 0, 0, 8'h01));
    send_word(CMD_READ, make_read(0));
    send_word(CMD_READ, make_read(PAGE_BYTES - 1));
    send_word(CMD_READ, make_read(PAGE_BYTES));
    send_word(CMD_READ, make_read(511));
    send_word(CMD_READ, make_read(200));
    s_tvalid <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      wait_drain();
      case (phase)
        0: load_settings(1'b1, 1'b1, 1'b0, 1'b1);
        1: load_settings(1'b0, 1'b0, 1'b1, 1'b1);
        2: load_settings(1'b1, 1'b1, 1'b1, 1'b1);
        3: load_settings(1'b0, 1'b0, 1'b0, 1'b0);
        4: load_settings(1'b1, 1'b0, 1'b1, 1'b0);
        default: load_settings(1'b0, 1'b1, 1'b0, 1'b1);
      endcase
      case (phase)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 60; rx_pct = 60; end
        2: begin tx_pct = 20; rx_pct = 40; end
        3: begin tx_pct = 40; rx_pct = 10; end
        4: begin tx_pct = 0;  rx_pct = 50; end
        default: begin tx_pct = 50; rx_pct = 0; end
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
          send_glyph();
        end else if (pick < 85) begin
          send_word(CMD_READ, make_read(($urandom_range(7, 0) == 0) ?
                    $urandom_range(511, 0) : $urandom_range(PAGE_BYTES - 1, 0)));
        end else begin
          noise = {$urandom, $urandom};
          noise[IN_W-1:60] = '0;
          send_word(1'($urandom_range(1, 0)), noise);
        end
      end
      s_tvalid <= 1'b0;
    end

    wait_drain();
    if (fail_count == 0 && pending == 0) begin
      $display("bit_aligned_glyph_blit_test OK");
    end else begin
      $display("bit_aligned_glyph_blit_test NOT OK");
    end
    $finish;
  end

endmodule
